// ----- rtl/core/abts_pkg.sv -----
// ----------------------------------------------------------------------------
// abts_pkg: shared definitions for the array binary tree store
// Holds the store geometry, operation and status codes, the request and
// result payload types, the controller/datapath interface structs and the
// value width conversion helpers.
// ----------------------------------------------------------------------------
`default_nettype none

package abts_pkg;

  // Store geometry.
  localparam int SLOTS      = 63;
  localparam int VALUE_BITS = 16;
  localparam int ADDR_W     = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int CNT_W      = $clog2(SLOTS + 1);
  localparam int WIDE_W     = ADDR_W + 2;

  // Operation codes.
  localparam logic [1:0] OP_INSERT   = 2'd0;
  localparam logic [1:0] OP_TRAVERSE = 2'd1;
  localparam logic [1:0] OP_DELETE   = 2'd2;
  localparam logic [1:0] OP_UNUSED   = 2'd3;

  // Result status codes.
  localparam logic [2:0] ST_INSERTED  = 3'd0;
  localparam logic [2:0] ST_OCCUPIED  = 3'd1;
  localparam logic [2:0] ST_OUT_RANGE = 3'd2;
  localparam logic [2:0] ST_DELETED   = 3'd3;
  localparam logic [2:0] ST_NOT_FOUND = 3'd4;
  localparam logic [2:0] ST_TRAV_VAL  = 3'd5;
  localparam logic [2:0] ST_EMPTY     = 3'd6;

  typedef struct packed {
    logic [1:0]         opcode;
    logic signed [15:0] value;
    logic [7:0]         slot;
  } req_t;

  typedef struct packed {
    logic [2:0]         status;
    logic signed [15:0] value_res;
    logic [7:0]         slot_index;
    logic               last;
  } res_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;
    logic ins_exec;
    logic trv_empty;
    logic cur_left;
    logic cur_right;
    logic cur_parent;
    logic pend_emit;
    logic pend_last;
    logic pend_load;
    logic scan;
    logic del_hit;
    logic del_miss;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic root_occ;
    logic left_ok;
    logic right_ok;
    logic cur_root;
    logic cur_odd;
    logic has_pend;
    logic val_zero;
    logic scan_hit;
    logic scan_end;
  } stat_t;

  // Narrow or widen a 16-bit request value to the stored width.
  function automatic logic [VALUE_BITS-1:0] to_store(input logic signed [15:0] v);
    logic signed [31:0] w;
    w = 32'(v);
    return w[VALUE_BITS-1:0];
  endfunction

  // Sign-extend a stored value and cut it to the 16-bit result field.
  function automatic logic signed [15:0] to_out(input logic [VALUE_BITS-1:0] s);
    logic signed [31:0] w;
    w = 32'(signed'(s));
    return w[15:0];
  endfunction

endpackage

`default_nettype wire

// ----- rtl/core/array_binary_tree_store.sv -----
// Insert registers the request and gives its result from the insert state;
// delete scans the memory with one read per cycle until a match or the last
// slot. Traverse is paced by the single memory read port and the cursor
// walk. One request is in flight at a time, and the next is taken at the
// earliest at the edge that ends the previous request's final result.
// Reset clears the occupancy bits and the sequencer; results cannot be
// stalled and show for one cycle.
// ----------------------------------------------------------------------------
// array_binary_tree_store: implicit binary tree held in a slot array
// Slot i has children at 2i+1 and 2i+2 and a zero marks an empty slot. The
// block inserts into a chosen slot, deletes the first matching value and
// walks the tree in order, skipping subtrees whose root is empty.
// ----------------------------------------------------------------------------
`default_nettype none

module array_binary_tree_store (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           start,
  output logic                busy,
  input  wire abts_pkg::req_t req,
  output logic                res_valid,
  output abts_pkg::res_t      res
);

  // The controller only sequences; all storage lives in the datapath. A
  // request is taken when start is high while busy is low, and busy stays
  // high until the last result of that request has been loaded into the
  // output register.
  abts_pkg::cmd_t  cmd;
  abts_pkg::stat_t stat;

  // The in-order walk keeps a one-deep pending result so that the last
  // flag can be set once the walk knows no successor exists. Emptiness is
  // tracked in per-slot occupancy flip-flops, so the memory itself never
  // needs a clearing pass after reset.
  abts_ctrl u_ctrl (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .opcode (req.opcode),
    .stat   (stat),
    .cmd    (cmd),
    .busy   (busy)
  );

  abts_datapath u_datapath (
    .clk       (clk),
    .rst       (rst),
    .req       (req),
    .cmd       (cmd),
    .stat      (stat),
    .res_valid (res_valid),
    .res       (res)
  );

`ifndef SYNTHESIS
  // The final result of a request coincides with the sequencer going idle.
  a_last_idle: assert property (@(posedge clk) disable iff (rst)
    res_valid && res.last |-> !busy)
    else $error("final result seen while still busy");

  // Intermediate traversal results only occur while the walk continues.
  a_mid_busy: assert property (@(posedge clk) disable iff (rst)
    res_valid && !res.last |-> busy)
    else $error("intermediate result seen while idle");

  // The unused opcode produces no result.
  a_unused_quiet: assert property (@(posedge clk) disable iff (rst)
    start && !busy && (req.opcode == abts_pkg::OP_UNUSED) |=> !res_valid)
    else $error("result produced for unused opcode");
`endif

endmodule

`default_nettype wire

// ----- rtl/core/abts_datapath.sv -----
// ----------------------------------------------------------------------------
// abts_datapath: storage and result datapath of the tree store
// Holds the value memory, the occupancy bits, the traversal cursor, the
// delete scan pointer, the pending traversal result and the result register.
// ----------------------------------------------------------------------------
`default_nettype none

module abts_datapath (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire abts_pkg::req_t req,
  input  wire abts_pkg::cmd_t cmd,
  output abts_pkg::stat_t     stat,
  output logic                res_valid,
  output abts_pkg::res_t      res
);

  logic [abts_pkg::VALUE_BITS-1:0] mem [abts_pkg::SLOTS];
  logic [abts_pkg::SLOTS-1:0]      occ;

  logic [abts_pkg::VALUE_BITS-1:0] req_val;
  logic [7:0]                      req_slot;
  logic [abts_pkg::ADDR_W-1:0]     cur;
  logic [abts_pkg::CNT_W-1:0]      sidx;
  logic                            cmp_vld;
  logic [abts_pkg::ADDR_W-1:0]     rd_idx;
  logic [abts_pkg::VALUE_BITS-1:0] rdata;
  logic                            pend_vld;
  logic [abts_pkg::VALUE_BITS-1:0] pend_val;
  logic [abts_pkg::ADDR_W-1:0]     pend_slot;

  logic [abts_pkg::WIDE_W-1:0] left_w;
  logic [abts_pkg::WIDE_W-1:0] right_w;
  logic [abts_pkg::ADDR_W-1:0] parent;
  logic [abts_pkg::ADDR_W-1:0] rd_addr;
  logic [abts_pkg::ADDR_W-1:0] slot_idx;
  logic                        slot_ok;
  logic                        ins_ok;
  logic                        emit;
  abts_pkg::res_t              res_next;

  assign left_w   = abts_pkg::WIDE_W'({cur, 1'b1});
  assign right_w  = abts_pkg::WIDE_W'({cur, 1'b0}) + abts_pkg::WIDE_W'(2);
  assign parent   = abts_pkg::ADDR_W'((cur - abts_pkg::ADDR_W'(1)) >> 1);
  assign rd_addr  = cmd.scan ? sidx[abts_pkg::ADDR_W-1:0] : cur;
  assign slot_ok  = req_slot < 8'(abts_pkg::SLOTS);
  assign slot_idx = req_slot[abts_pkg::ADDR_W-1:0];
  assign ins_ok   = slot_ok && !occ[slot_idx];

  assign stat.root_occ = occ[0];
  assign stat.left_ok  = (left_w < abts_pkg::WIDE_W'(abts_pkg::SLOTS)) &&
                         occ[left_w[abts_pkg::ADDR_W-1:0]];
  assign stat.right_ok = (right_w < abts_pkg::WIDE_W'(abts_pkg::SLOTS)) &&
                         occ[right_w[abts_pkg::ADDR_W-1:0]];
  assign stat.cur_root = (cur == '0);
  assign stat.cur_odd  = cur[0];
  assign stat.has_pend = pend_vld;
  assign stat.val_zero = (req_val == '0);
  assign stat.scan_hit = cmp_vld && occ[rd_idx] && (rdata == req_val);
  assign stat.scan_end = cmp_vld && (rd_idx == abts_pkg::ADDR_W'(abts_pkg::SLOTS - 1));

  // Value memory: one write and one registered read per cycle.
  always_ff @(posedge clk) begin
    if (cmd.ins_exec && ins_ok) begin
      mem[slot_idx] <= req_val;
    end
    rdata  <= mem[rd_addr];
    rd_idx <= rd_addr;
  end

  always_comb begin
    res_next.status     = abts_pkg::ST_NOT_FOUND;
    res_next.value_res  = abts_pkg::to_out(req_val);
    res_next.slot_index = '0;
    res_next.last       = 1'b1;
    if (cmd.ins_exec) begin
      res_next.slot_index = req_slot;
      if (!slot_ok) begin
        res_next.status = abts_pkg::ST_OUT_RANGE;
      end else if (occ[slot_idx]) begin
        res_next.status = abts_pkg::ST_OCCUPIED;
      end else begin
        res_next.status = abts_pkg::ST_INSERTED;
      end
    end else if (cmd.trv_empty) begin
      res_next.status    = abts_pkg::ST_EMPTY;
      res_next.value_res = '0;
    end else if (cmd.del_hit) begin
      res_next.status     = abts_pkg::ST_DELETED;
      res_next.slot_index = 8'(rd_idx);
    end else if (cmd.pend_emit) begin
      res_next.status     = abts_pkg::ST_TRAV_VAL;
      res_next.value_res  = abts_pkg::to_out(pend_val);
      res_next.slot_index = 8'(pend_slot);
      res_next.last       = cmd.pend_last;
    end
  end

  assign emit = cmd.ins_exec | cmd.trv_empty | cmd.pend_emit | cmd.del_hit | cmd.del_miss;

  // Control state.
  always_ff @(posedge clk) begin
    if (rst) begin
      occ       <= '0;
      cmp_vld   <= 1'b0;
      pend_vld  <= 1'b0;
      res_valid <= 1'b0;
    end else begin
      res_valid <= emit;
      cmp_vld   <= cmd.scan && (sidx < abts_pkg::CNT_W'(abts_pkg::SLOTS));
      if (cmd.ins_exec && ins_ok && (req_val != '0)) begin
        occ[slot_idx] <= 1'b1;
      end
      if (cmd.del_hit) begin
        occ[rd_idx] <= 1'b0;
      end
      if (cmd.load) begin
        pend_vld <= 1'b0;
      end else if (cmd.pend_load) begin
        pend_vld <= 1'b1;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      req_val  <= abts_pkg::to_store(req.value);
      req_slot <= req.slot;
      cur      <= '0;
      sidx     <= '0;
    end else begin
      if (cmd.cur_left) begin
        cur <= left_w[abts_pkg::ADDR_W-1:0];
      end else if (cmd.cur_right) begin
        cur <= right_w[abts_pkg::ADDR_W-1:0];
      end else if (cmd.cur_parent) begin
        cur <= parent;
      end
      if (cmd.scan && (sidx < abts_pkg::CNT_W'(abts_pkg::SLOTS))) begin
        sidx <= sidx + abts_pkg::CNT_W'(1);
      end
    end
    if (cmd.pend_load) begin
      pend_val  <= rdata;
      pend_slot <= rd_idx;
    end
    if (emit) begin
      res <= res_next;
    end
  end

endmodule

`default_nettype wire

// ----- rtl/core/abts_ctrl.sv -----
// ----------------------------------------------------------------------------
// abts_ctrl: operation sequencer of the tree store
// Dispatches each request and steps insert, delete scan and in-order walk.
// ----------------------------------------------------------------------------
`default_nettype none

module abts_ctrl (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            start,
  input  wire logic [1:0]      opcode,
  input  wire abts_pkg::stat_t stat,
  output abts_pkg::cmd_t       cmd,
  output logic                 busy
);

  typedef enum logic [7:0] {
    S_IDLE   = 8'b0000_0001,
    S_INS    = 8'b0000_0010,
    S_TROOT  = 8'b0000_0100,
    S_TDESC  = 8'b0000_1000,
    S_TRD    = 8'b0001_0000,
    S_TFOUND = 8'b0010_0000,
    S_TUP    = 8'b0100_0000,
    S_DEL    = 8'b1000_0000
  } state_t;

  state_t state;
  state_t state_next;

  assign busy = (state != S_IDLE);

  always_comb begin
    state_next = state;
    cmd        = '0;
    case (state)
      S_IDLE: begin
        if (start) begin
          case (opcode)
            abts_pkg::OP_INSERT: begin
              cmd.load   = 1'b1;
              state_next = S_INS;
            end
            abts_pkg::OP_TRAVERSE: begin
              cmd.load   = 1'b1;
              state_next = S_TROOT;
            end
            abts_pkg::OP_DELETE: begin
              cmd.load   = 1'b1;
              state_next = S_DEL;
            end
            default: begin
              state_next = S_IDLE;
            end
          endcase
        end
      end
      S_INS: begin
        cmd.ins_exec = 1'b1;
        state_next   = S_IDLE;
      end
      S_TROOT: begin
        if (!stat.root_occ) begin
          cmd.trv_empty = 1'b1;
          state_next    = S_IDLE;
        end else begin
          state_next = S_TDESC;
        end
      end
      S_TDESC: begin
        if (stat.left_ok) begin
          cmd.cur_left = 1'b1;
        end else begin
          state_next = S_TFOUND;
        end
      end
      S_TRD: begin
        state_next = S_TFOUND;
      end
      S_TFOUND: begin
        cmd.pend_emit = stat.has_pend;
        cmd.pend_load = 1'b1;
        if (stat.right_ok) begin
          cmd.cur_right = 1'b1;
          state_next    = S_TDESC;
        end else begin
          state_next = S_TUP;
        end
      end
      S_TUP: begin
        if (stat.cur_root) begin
          cmd.pend_emit = 1'b1;
          cmd.pend_last = 1'b1;
          state_next    = S_IDLE;
        end else if (stat.cur_odd) begin
          cmd.cur_parent = 1'b1;
          state_next     = S_TRD;
        end else begin
          cmd.cur_parent = 1'b1;
        end
      end
      S_DEL: begin
        if (stat.val_zero || (stat.scan_end && !stat.scan_hit)) begin
          cmd.del_miss = 1'b1;
          state_next   = S_IDLE;
        end else if (stat.scan_hit) begin
          cmd.del_hit = 1'b1;
          state_next  = S_IDLE;
        end else begin
          cmd.scan = 1'b1;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

`default_nettype wire

// ----- verif/tree_store_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tree_store_checker: result predictor and scoreboard for the tree store
// Keeps its own copy of the slot array, works out the results of every
// accepted request and compares each strobed result with the oldest one
// still awaited.
// ----------------------------------------------------------------------------
module tree_store_checker
  import abts_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic start,
  input  logic busy,
  input  req_t req,
  input  logic res_valid,
  input  res_t res,
  output int   pending,
  output int   failures
);

  localparam int PRINT_CAP = 40;

  logic [VALUE_BITS-1:0] slot_mirror [SLOTS];
  res_t                  awaited_results [$];

  // Request values are sign-extended, then cut to the stored width.
  function automatic logic [VALUE_BITS-1:0] narrow_value(input logic [15:0] v);
    logic [31:0] wide;
    wide = {{16{v[15]}}, v};
    return wide[VALUE_BITS-1:0];
  endfunction

  // Stored values are sign-extended, then cut to the 16-bit result field.
  function automatic logic [15:0] widen_value(input logic [VALUE_BITS-1:0] s);
    logic [31:0] wide;
    wide = {{(32 - VALUE_BITS){s[VALUE_BITS-1]}}, s};
    return wide[15:0];
  endfunction

  function automatic res_t make_result(input logic [2:0] code, input logic [15:0] val,
                                       input logic [7:0] idx, input logic fin);
    res_t r;
    r.status     = code;
    r.value_res  = val;
    r.slot_index = idx;
    r.last       = fin;
    return r;
  endfunction

  task automatic predict_request(input req_t r);
    logic [VALUE_BITS-1:0] stored;
    int                    idx;
    int                    sp;
    int                    path [16];
    bit                    found;
    stored = narrow_value(r.value);
    case (r.opcode)
      OP_INSERT: begin
        if (r.slot >= SLOTS) begin
          awaited_results.push_back(make_result(ST_OUT_RANGE, widen_value(stored), r.slot, 1'b1));
        end else if (slot_mirror[r.slot] != '0) begin
          awaited_results.push_back(make_result(ST_OCCUPIED, widen_value(stored), r.slot, 1'b1));
        end else begin
          slot_mirror[r.slot] = stored;
          awaited_results.push_back(make_result(ST_INSERTED, widen_value(stored), r.slot, 1'b1));
        end
      end
      OP_TRAVERSE: begin
        if (slot_mirror[0] == '0) begin
          awaited_results.push_back(make_result(ST_EMPTY, 16'd0, 8'd0, 1'b1));
        end else begin
          // Iterative in-order walk; an empty slot ends the descent.
          idx = 0;
          sp  = 0;
          while (sp > 0 || (idx < SLOTS && slot_mirror[idx] != '0)) begin
            while (idx < SLOTS && slot_mirror[idx] != '0) begin
              path[sp] = idx;
              sp++;
              idx = 2 * idx + 1;
            end
            sp--;
            idx = path[sp];
            awaited_results.push_back(make_result(ST_TRAV_VAL, widen_value(slot_mirror[idx]),
                                                  8'(idx), 1'b0));
            idx = 2 * idx + 2;
          end
          awaited_results[awaited_results.size() - 1].last = 1'b1;
        end
      end
      OP_DELETE: begin
        found = 1'b0;
        if (stored != '0) begin
          for (int i = 0; i < SLOTS; i++) begin
            if (!found && slot_mirror[i] == stored) begin
              slot_mirror[i] = '0;
              found = 1'b1;
              awaited_results.push_back(make_result(ST_DELETED, widen_value(stored), 8'(i),
                                                    1'b1));
            end
          end
        end
        if (!found) begin
          awaited_results.push_back(make_result(ST_NOT_FOUND, widen_value(stored), 8'd0, 1'b1));
        end
      end
      default: begin
      end
    endcase
  endtask

  task automatic report_mismatch(input string what, input res_t got, input res_t want);
    if (failures < PRINT_CAP) begin
      $display("[%0t] tree store mismatch, %s: got st=%0d val=%0d slot=%0d last=%0b, want st=%0d val=%0d slot=%0d last=%0b",
               $time, what, got.status, got.value_res, got.slot_index, got.last,
               want.status, want.value_res, want.slot_index, want.last);
    end
    failures++;
  endtask

  always @(posedge clk) begin : watch
    res_t want;
    if (rst) begin
      for (int i = 0; i < SLOTS; i++) begin
        slot_mirror[i] = '0;
      end
      awaited_results.delete();
    end else begin
      // A result always belongs to an earlier request, so compare first.
      if (res_valid) begin
        if (awaited_results.size() == 0) begin
          report_mismatch("result with nothing awaited", res, '0);
        end else begin
          want = awaited_results.pop_front();
          if (res.status !== want.status) report_mismatch("status", res, want);
          if (res.value_res !== want.value_res) report_mismatch("value_res", res, want);
          if (res.slot_index !== want.slot_index) report_mismatch("slot_index", res, want);
          if (res.last !== want.last) report_mismatch("last", res, want);
        end
      end
      if (start && !busy) begin
        predict_request(req);
      end
    end
    pending <= awaited_results.size();
  end

endmodule

// ----- verif/array_binary_tree_store_test.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// array_binary_tree_store_test: stimulus and verdict for the tree store
// Drives a directed set of requests covering every operation and corner case,
// then a long run of random request mixes with random gaps. The checker
// instance predicts and compares all results; this module only decides when
// to stop and whether the run passed.
// ----------------------------------------------------------------------------
module array_binary_tree_store_test;
  import abts_pkg::*;

  // Number of random requests that produce results (ignored opcodes excluded).
  localparam int ITEM_TARGET = 380;
  // Cycles without any accepted request or result before the run is abandoned.
  // The slowest legitimate quiet stretch is a long sender gap followed by a
  // full delete scan, well under this.
  localparam int IDLE_LIMIT  = 4000;
  // Cycles allowed after the last awaited result for any stray output, sized
  // from the length of a full traversal.
  localparam int TAIL_CYCLES = 4 * SLOTS + 16;

  // Random request mixes: filling the tree, emptying it, or a bit of both.
  typedef enum {MIX_FILL, MIX_DRAIN, MIX_BALANCED} mix_t;

  logic clk;
  logic rst;
  logic start;
  logic busy;
  req_t req;
  logic res_valid;
  res_t res;

  int pending;
  int failures;
  int idle_cycles;
  int issued;
  bit no_gaps;

  // Values recently inserted, so that deletes mostly hit something.
  logic [15:0] value_pool [$];

  array_binary_tree_store u_dut (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .busy      (busy),
    .req       (req),
    .res_valid (res_valid),
    .res       (res)
  );

  tree_store_checker u_checker (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .busy      (busy),
    .req       (req),
    .res_valid (res_valid),
    .res       (res),
    .pending   (pending),
    .failures  (failures)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Watchdog: any accepted request or any result counts as progress.
  always @(posedge clk) begin
    if (rst || (start && !busy) || res_valid) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // Sender gap before each request: mostly none, some short, a few long.
  // Segments with no_gaps set run requests back to back.
  function automatic int pick_gap();
    int roll;
    if (no_gaps) return 0;
    roll = $urandom_range(0, 99);
    if (roll < 60) return 0;
    if (roll < 90) return $urandom_range(1, 3);
    if (roll < 98) return $urandom_range(4, 20);
    return $urandom_range(30, 100);
  endfunction

  function automatic req_t build_request(input logic [1:0] op, input logic [15:0] val,
                                         input logic [7:0] idx);
    req_t r;
    r.opcode = op;
    r.value  = val;
    r.slot   = idx;
    return r;
  endfunction

  // Presents one request and returns at the edge where it is accepted. Start
  // is left high so that a back-to-back request needs no second assignment
  // to it in the same time step.
  task automatic send_request(input req_t r);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start <= 1'b1;
    req   <= r;
    do @(posedge clk); while (busy);
    if (r.opcode != OP_UNUSED) issued++;
  endtask

  // Holds the sender off until every awaited result has come back. The
  // checker registers its count at the acceptance edge, so the task waits past
  // that edge before reading it.
  task automatic wait_for_results();
    start <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  // Random request with content shaped by the mix. Inserts favor the upper
  // levels of the tree so traversals go deep; deletes mostly name a value
  // that was inserted recently.
  function automatic req_t random_request(input mix_t mix);
    req_t r;
    int   roll;
    int   ins_pct;
    int   del_pct;
    int   trv_pct;
    int   pick;
    r.opcode = OP_INSERT;
    r.value  = 16'($urandom);
    r.slot   = 8'($urandom);
    case (mix)
      MIX_FILL: begin
        ins_pct = 70; del_pct = 10; trv_pct = 15;
      end
      MIX_DRAIN: begin
        ins_pct = 20; del_pct = 60; trv_pct = 15;
      end
      default: begin
        ins_pct = 40; del_pct = 30; trv_pct = 25;
      end
    endcase
    roll = $urandom_range(0, 99);
    if (roll < ins_pct) begin
      pick = $urandom_range(0, 99);
      if (pick < 5) begin
        r.value = 16'd0;
      end else if (pick < 20) begin
        // Small values, both signs, so duplicates appear in the tree.
        r.value = 16'(int'($urandom_range(0, 11)) - 6);
      end
      pick = $urandom_range(0, 99);
      if (pick < 40) begin
        r.slot = 8'($urandom_range(0, 14));
      end else if (pick < 88) begin
        r.slot = 8'($urandom_range(0, SLOTS - 1));
      end else begin
        r.slot = 8'($urandom_range(SLOTS, 255));
      end
      value_pool.push_back(r.value);
      if (value_pool.size() > 48) void'(value_pool.pop_front());
    end else if (roll < ins_pct + del_pct) begin
      r.opcode = OP_DELETE;
      if (value_pool.size() > 0 && $urandom_range(0, 99) < 70) begin
        pick    = $urandom_range(0, value_pool.size() - 1);
        r.value = value_pool[pick];
        value_pool.delete(pick);
      end else if ($urandom_range(0, 9) == 0) begin
        r.value = 16'd0;
      end
    end else if (roll < ins_pct + del_pct + trv_pct) begin
      r.opcode = OP_TRAVERSE;
    end else begin
      r.opcode = OP_UNUSED;
    end
    return r;
  endfunction

  initial begin
    mix_t mix;
    int   seg_len;
    bit   paused_mid;
    rst        = 1'b1;
    start      = 1'b0;
    req        = '0;
    no_gaps    = 1'b0;
    paused_mid = 1'b0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed part. The tree starts empty after reset.
    send_request(build_request(OP_TRAVERSE, 16'h0000, 8'd0));   // empty tree
    send_request(build_request(OP_DELETE,   16'h0000, 8'd0));   // zero is never found
    send_request(build_request(OP_DELETE,   16'h0005, 8'd0));   // miss on empty tree
    send_request(build_request(OP_INSERT,   16'h0000, 8'd0));   // zero insert leaves slot empty
    send_request(build_request(OP_TRAVERSE, 16'h0000, 8'd0));   // still empty
    send_request(build_request(OP_INSERT,   16'h7FFF, 8'd1));   // below an empty root
    send_request(build_request(OP_TRAVERSE, 16'hFFFF, 8'hFF));  // root empty: child hidden
    send_request(build_request(OP_INSERT,   16'h8000, 8'd0));   // most negative at the root
    send_request(build_request(OP_INSERT,   16'hFFFF, 8'd2));   // minus one
    send_request(build_request(OP_INSERT,   16'h0001, 8'(SLOTS - 1))); // last slot
    send_request(build_request(OP_INSERT,   16'h0007, 8'(SLOTS))); // first slot out of range
    send_request(build_request(OP_INSERT,   16'h0009, 8'hFF));  // largest slot field
    send_request(build_request(OP_INSERT,   16'h0003, 8'd0));   // occupied
    send_request(build_request(OP_UNUSED,   16'hFFFF, 8'hFF));  // ignored opcode
    send_request(build_request(OP_TRAVERSE, 16'h0000, 8'd0));
    send_request(build_request(OP_INSERT,   16'h8000, 8'd5));   // duplicate deeper down
    send_request(build_request(OP_DELETE,   16'h8000, 8'd0));   // first match is the root
    send_request(build_request(OP_TRAVERSE, 16'h0000, 8'd0));   // root gone: empty again
    send_request(build_request(OP_DELETE,   16'h8000, 8'd0));   // now the deeper copy
    send_request(build_request(OP_DELETE,   16'h1234, 8'd0));   // not found
    send_request(build_request(OP_INSERT,   16'h1234, 8'd0));
    send_request(build_request(OP_TRAVERSE, 16'h0000, 8'd0));

    // Let everything come back before the random part starts.
    wait_for_results();

    // Random part in segments, each with its own mix and gap behavior.
    issued = 0;
    while (issued < ITEM_TARGET) begin
      mix     = mix_t'($urandom_range(0, 2));
      no_gaps = ($urandom_range(0, 3) == 0);
      seg_len = $urandom_range(15, 40);
      repeat (seg_len) send_request(random_request(mix));
      if (!paused_mid && issued >= ITEM_TARGET / 2) begin
        wait_for_results();
        paused_mid = 1'b1;
      end
    end

    // Drain, then give the block time to show any result nobody asked for.
    wait_for_results();
    repeat (TAIL_CYCLES) @(posedge clk);

    if (failures == 0 && pending == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
rtl/core/abts_pkg.sv
rtl/core/abts_datapath.sv
rtl/core/abts_ctrl.sv
rtl/core/array_binary_tree_store.sv
verif/tree_store_checker.sv
verif/array_binary_tree_store_test.sv
